/* rtl/spll_pkg.sv */
// shared types, codes and defaults for the shared pool linked lists block
package spll_pkg;

  localparam int POOL_NODES_DEF = 16;
  localparam int LIST_COUNT_DEF = 4;
  localparam int DATA_BITS_DEF  = 64;

  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_APOP,
    S_AWALK,
    S_DWALK,
    S_RPOP,
    S_FREE,
    S_RESP
  } state_t;

endpackage

/* rtl/spll_ram.sv */
// generic single write port ram with registered read
module spll_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/shared_pool_linked_lists.sv */
// top level: several linked lists in one node pool with a free list
//
// One request is taken at a time; req_stall stays high from the cycle after
// acceptance until the result has been loaded into the output register.
// Each step of a walk is one read through the single read port of the link
// and data memories, which share one read address. An append passes decode,
// the take of a free node, a walk to the list tail if the list is not empty
// and the result state; a delete walks from the head to the match and frees
// that node, or stops at the tail when none matches; a remove head reads the
// head and frees it; and a request that fails at once goes from decode to
// the result state. A new request is taken while an earlier result still
// waits in the output register. Node links that were never written are
// covered by a fill count, so there is no clearing pass after reset.
module shared_pool_linked_lists #(
  parameter int POOL_NODES = spll_pkg::POOL_NODES_DEF,
  parameter int LIST_COUNT = spll_pkg::LIST_COUNT_DEF,
  parameter int DATA_BITS  = spll_pkg::DATA_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [1:0]  operation,
  input  logic [1:0]  list_id,
  input  logic [63:0] value,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [1:0]  status,
  output logic [63:0] data_out,
  output logic [3:0]  slot
);

  localparam int IW = $clog2(POOL_NODES);
  localparam int PW = $clog2(POOL_NODES + 1);
  localparam int LW = (LIST_COUNT > 1) ? $clog2(LIST_COUNT) : 1;
  localparam logic [PW-1:0] NONE = PW'(POOL_NODES);
  localparam logic [PW-1:0] LAST = PW'(POOL_NODES - 1);

  spll_pkg::state_t state, state_next;

  logic [1:0]           op_q;
  logic [1:0]           lid_q;
  logic [DATA_BITS-1:0] val_q;
  logic [PW-1:0]        node_q, node_next;
  logic                 fresh_q, fresh_next;
  logic [PW-1:0]        cur, cur_next;
  logic [PW-1:0]        prev, prev_next;
  logic [PW-1:0]        free_head, free_head_next;
  logic [PW-1:0]        fill, fill_next;
  logic [PW-1:0]        list_head [LIST_COUNT];
  logic [PW-1:0]        list_head_next [LIST_COUNT];
  logic [1:0]           r_status, r_status_next;
  logic [DATA_BITS-1:0] r_data, r_data_next;
  logic [3:0]           r_slot, r_slot_next;

  logic                 link_we, data_we;
  logic [IW-1:0]        link_waddr, data_waddr, rd_addr;
  logic [PW-1:0]        link_wdata, link_rd;
  logic [DATA_BITS-1:0] data_wdata, data_rd;

  logic          accept, out_free, list_ok;
  logic [LW-1:0] lidx;
  logic [PW-1:0] head_sel, fresh_link;

  assign accept     = req_valid && !req_stall;
  assign req_stall  = (state != spll_pkg::S_IDLE);
  assign out_free   = !res_valid || !res_stall;
  assign list_ok    = ({3'b000, lid_q} < 5'(LIST_COUNT));
  assign lidx       = LW'(lid_q);
  assign head_sel   = list_head[lidx];
  assign fresh_link = (node_q == LAST) ? NONE : node_q + 1'b1;

  spll_ram #(.WIDTH(PW), .DEPTH(POOL_NODES)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (rd_addr),
    .rdata (link_rd)
  );

  spll_ram #(.WIDTH(DATA_BITS), .DEPTH(POOL_NODES)) u_data_ram (
    .clk   (clk),
    .we    (data_we),
    .waddr (data_waddr),
    .wdata (data_wdata),
    .raddr (rd_addr),
    .rdata (data_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spll_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    node_next      = node_q;
    fresh_next     = fresh_q;
    cur_next       = cur;
    prev_next      = prev;
    free_head_next = free_head;
    fill_next      = fill;
    list_head_next = list_head;
    r_status_next  = r_status;
    r_data_next    = r_data;
    r_slot_next    = r_slot;
    link_we        = 1'b0;
    link_waddr     = '0;
    link_wdata     = NONE;
    data_we        = 1'b0;
    data_waddr     = '0;
    data_wdata     = '0;
    rd_addr        = '0;
    case (state)
      spll_pkg::S_IDLE: begin
        if (req_valid) begin
          state_next = spll_pkg::S_DECODE;
        end
      end
      spll_pkg::S_DECODE: begin
        r_status_next = spll_pkg::ST_OK;
        r_data_next   = '0;
        r_slot_next   = '0;
        state_next    = spll_pkg::S_RESP;
        if (!list_ok) begin
          r_status_next = spll_pkg::ST_EMPTY;
        end else begin
          case (op_q)
            spll_pkg::OP_APPEND: begin
              if (free_head == NONE) begin
                r_status_next = spll_pkg::ST_FULL;
              end else begin
                rd_addr    = IW'(free_head);
                fresh_next = (free_head >= fill);
                node_next  = free_head;
                state_next = spll_pkg::S_APOP;
              end
            end
            spll_pkg::OP_DELETE, spll_pkg::OP_REMOVE: begin
              if (head_sel == NONE) begin
                r_status_next = spll_pkg::ST_EMPTY;
              end else begin
                rd_addr    = IW'(head_sel);
                cur_next   = head_sel;
                prev_next  = NONE;
                state_next = (op_q == spll_pkg::OP_DELETE) ? spll_pkg::S_DWALK
                                                           : spll_pkg::S_RPOP;
              end
            end
            default: begin
            end
          endcase
        end
      end
      spll_pkg::S_APOP: begin
        free_head_next = fresh_q ? fresh_link : link_rd;
        if (fresh_q) begin
          fill_next = fill + 1'b1;
        end
        data_we     = 1'b1;
        data_waddr  = IW'(node_q);
        data_wdata  = val_q;
        link_we     = 1'b1;
        link_waddr  = IW'(node_q);
        link_wdata  = NONE;
        r_slot_next = 4'(node_q);
        if (head_sel == NONE) begin
          list_head_next[lidx] = node_q;
          state_next = spll_pkg::S_RESP;
        end else begin
          rd_addr    = IW'(head_sel);
          cur_next   = head_sel;
          state_next = spll_pkg::S_AWALK;
        end
      end
      spll_pkg::S_AWALK: begin
        if (link_rd != NONE) begin
          cur_next = link_rd;
          rd_addr  = IW'(link_rd);
        end else begin
          link_we    = 1'b1;
          link_waddr = IW'(cur);
          link_wdata = node_q;
          state_next = spll_pkg::S_RESP;
        end
      end
      spll_pkg::S_DWALK: begin
        if (data_rd == val_q) begin
          if (prev != NONE) begin
            link_we    = 1'b1;
            link_waddr = IW'(prev);
            link_wdata = link_rd;
          end else begin
            list_head_next[lidx] = link_rd;
          end
          r_data_next = data_rd;
          r_slot_next = 4'(cur);
          state_next  = spll_pkg::S_FREE;
        end else if (link_rd != NONE) begin
          prev_next = cur;
          cur_next  = link_rd;
          rd_addr   = IW'(link_rd);
        end else begin
          r_status_next = spll_pkg::ST_NOTFOUND;
          state_next    = spll_pkg::S_RESP;
        end
      end
      spll_pkg::S_RPOP: begin
        list_head_next[lidx] = link_rd;
        r_data_next = data_rd;
        r_slot_next = 4'(cur);
        state_next  = spll_pkg::S_FREE;
      end
      spll_pkg::S_FREE: begin
        link_we        = 1'b1;
        link_waddr     = IW'(cur);
        link_wdata     = free_head;
        data_we        = 1'b1;
        data_waddr     = IW'(cur);
        data_wdata     = '0;
        free_head_next = cur;
        state_next     = spll_pkg::S_RESP;
      end
      spll_pkg::S_RESP: begin
        if (out_free) begin
          state_next = spll_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = spll_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_head <= '0;
      fill      <= '0;
      res_valid <= 1'b0;
      for (int i = 0; i < LIST_COUNT; i++) begin
        list_head[i] <= NONE;
      end
    end else begin
      free_head <= free_head_next;
      fill      <= fill_next;
      list_head <= list_head_next;
      if (state == spll_pkg::S_RESP && out_free) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q  <= operation;
      lid_q <= list_id;
      val_q <= value[DATA_BITS-1:0];
    end
    node_q   <= node_next;
    fresh_q  <= fresh_next;
    cur      <= cur_next;
    prev     <= prev_next;
    r_status <= r_status_next;
    r_data   <= r_data_next;
    r_slot   <= r_slot_next;
    if (state == spll_pkg::S_RESP && out_free) begin
      status   <= r_status;
      data_out <= 64'(r_data);
      slot     <= r_slot;
    end
  end

  a_full_pool: assert property (@(posedge clk) disable iff (rst)
    (free_head == NONE) |-> (fill == NONE))
    else $error("free list empty before every node was taken");

  a_fill_hold: assert property (@(posedge clk) disable iff (rst)
    (state != spll_pkg::S_APOP) |=> $stable(fill))
    else $error("fill count moved outside a node take");

  a_start: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == spll_pkg::S_DECODE))
    else $error("request accepted without decode");

  a_load: assert property (@(posedge clk) disable iff (rst)
    (state == spll_pkg::S_RESP && out_free) |=> res_valid)
    else $error("result not presented");

  a_full_fields: assert property (@(posedge clk) disable iff (rst)
    (res_valid && status == spll_pkg::ST_FULL) |-> (data_out == 64'd0 && slot == 4'd0))
    else $error("pool full result carries data");

endmodule
